// File: design/arvr_pkg.sv
// Package for the audio ring with output volume ramp.
// Widths, register indexes, opcodes, payload structs and the sequencer state type.
// No dependencies.
`default_nettype none
package arvr_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int MAX_BLOCK  = 1024;
  localparam int LEN_W      = 11;
  localparam int GAIN_W     = 7;
  localparam int SAMPLE_W   = 16;
  localparam int FULL_GAIN  = 100;
  localparam int DIV_W      = 22;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 7;

  // 1/FULL_GAIN rounded up; exact floor for dividends below 2**DIV_W
  localparam int                RCP_SHIFT = DIV_W + 7;
  localparam int                RCP_W     = 23;
  localparam logic [RCP_W-1:0]  RCP_100   = RCP_W'((64'd1 << RCP_SHIFT) / FULL_GAIN + 1);

  localparam logic [CFG_AW-1:0] REG_VOLUME = 1'b0;
  localparam logic [CFG_AW-1:0] REG_MUTE   = 1'b1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_start;
    logic [LEN_W-1:0]           block_len;
  } req_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       push_accepted;
    logic                       from_ring;
    logic                       block_last;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_GSTART,
    ST_GWAIT,
    ST_MUL,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: design/arvr_if.sv
// Handshake channel interfaces: request items, response items, register writes.
// Depends on arvr_pkg.
`default_nettype none
interface arvr_req_if;
  logic                valid;
  logic                ready;
  arvr_pkg::req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface arvr_rsp_if;
  logic                valid;
  logic                ready;
  arvr_pkg::rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface arvr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [arvr_pkg::CFG_AW-1:0]   addr;
  logic [arvr_pkg::CFG_DW-1:0]   wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface
`default_nettype wire

// File: design/arvr_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on arvr_pkg for widths.
`default_nettype none
module arvr_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [arvr_pkg::DIV_W-1:0]    dividend,
  input  wire logic [arvr_pkg::LEN_W-1:0]    divisor,
  output logic                               done,
  output logic [arvr_pkg::DIV_W-1:0]         quotient
);

  logic                              running;
  logic [arvr_pkg::DIV_CNT_W-1:0]    cnt;
  logic [arvr_pkg::LEN_W-1:0]        rem;
  logic [arvr_pkg::LEN_W-1:0]        dsr;
  logic [arvr_pkg::LEN_W:0]          trial;
  logic                              fits;

  assign trial = {rem, quotient[arvr_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == arvr_pkg::DIV_CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= arvr_pkg::DIV_CNT_W'(arvr_pkg::DIV_W);
      end else if (running) begin
        cnt <= cnt - arvr_pkg::DIV_CNT_W'(1);
        if (cnt == arvr_pkg::DIV_CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      rem      <= fits ? arvr_pkg::LEN_W'(trial - {1'b0, dsr}) : trial[arvr_pkg::LEN_W-1:0];
      quotient <= {quotient[arvr_pkg::DIV_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: design/audio_ring_volume_ramp.sv
// Audio sample ring with linear output gain ramp over each output block.
// Push, or pull past the fill or after the block: IDLE, then DONE loads the output register.
// Pull from the ring: RD, GSTART, GWAIT on the 22-step ramp divide, MUL, SCALE, DONE; when
// the fill is one sample the divide is skipped. Scaling by 100 is a reciprocal multiply.
// One transaction in flight at a time; a held response stalls the input.
// Reset clears indexes, ramp and block state; volume returns to 100, mute to 0.
// Ring contents are not cleared and need no clearing pass.
`default_nettype none
module audio_ring_volume_ramp (
  input  wire logic  clk,
  input  wire logic  rst,
  arvr_req_if.sink   req,
  arvr_rsp_if.source rsp,
  arvr_cfg_if.sink   cfg
);

  arvr_pkg::state_t state, state_next;

  logic signed [arvr_pkg::SAMPLE_W-1:0] ring [arvr_pkg::RING_DEPTH];
  logic signed [arvr_pkg::SAMPLE_W-1:0] ring_rdata;

  logic [arvr_pkg::RING_AW-1:0]  write_index;
  logic [arvr_pkg::RING_AW-1:0]  read_index;
  logic [arvr_pkg::GAIN_W-1:0]   previous_gain;
  logic [arvr_pkg::LEN_W-1:0]    block_fill;
  logic [arvr_pkg::LEN_W-1:0]    block_position;
  logic [arvr_pkg::LEN_W-1:0]    block_length;
  logic [arvr_pkg::GAIN_W-1:0]   ramp_start;
  logic [arvr_pkg::GAIN_W-1:0]   ramp_end;
  logic [arvr_pkg::GAIN_W-1:0]   volume;
  logic                          mute;

  logic [arvr_pkg::LEN_W-1:0]          pos_cur;
  logic signed [arvr_pkg::SAMPLE_W-1:0] sample_q;
  logic [arvr_pkg::DIV_W-1:0]          num_abs;
  logic                                num_neg;
  logic [arvr_pkg::GAIN_W-1:0]         gain_q;
  logic [arvr_pkg::DIV_W-1:0]          prod_abs;
  logic                                prod_neg;
  arvr_pkg::rsp_item_t                 res;

  logic accept, load_out, div_start, div_done;
  logic [arvr_pkg::DIV_W-1:0] div_dividend, div_quotient;
  logic [arvr_pkg::LEN_W-1:0] div_divisor;

  // Decode of the incoming transaction against current block state.
  logic [arvr_pkg::RING_AW-1:0] count;
  logic                         full;
  logic [arvr_pkg::LEN_W-1:0]   len_sat, fill_new, eff_len, eff_fill, eff_pos;
  logic                         active, ring_pull, is_last, is_pull;
  logic [arvr_pkg::GAIN_W-1:0]  target;

  assign accept  = req.valid && req.ready;
  assign is_pull = req.data.opcode == arvr_pkg::OP_PULL;
  assign count   = write_index - read_index;
  assign full    = count == arvr_pkg::RING_AW'(arvr_pkg::RING_DEPTH - 1);

  always_comb begin
    if (req.data.block_len == '0) begin
      len_sat = arvr_pkg::LEN_W'(1);
    end else if (req.data.block_len > arvr_pkg::LEN_W'(arvr_pkg::MAX_BLOCK)) begin
      len_sat = arvr_pkg::LEN_W'(arvr_pkg::MAX_BLOCK);
    end else begin
      len_sat = req.data.block_len;
    end
    fill_new = (count < arvr_pkg::RING_AW'(len_sat)) ? arvr_pkg::LEN_W'(count) : len_sat;
    target   = (volume > arvr_pkg::GAIN_W'(arvr_pkg::FULL_GAIN)) ?
               arvr_pkg::GAIN_W'(arvr_pkg::FULL_GAIN) : volume;
    if (mute) begin
      target = '0;
    end
    eff_len   = req.data.block_start ? len_sat : block_length;
    eff_fill  = req.data.block_start ? fill_new : block_fill;
    eff_pos   = req.data.block_start ? '0 : block_position;
    active    = eff_pos < eff_len;
    ring_pull = active && (eff_pos < eff_fill);
    is_last   = active && ((eff_pos + arvr_pkg::LEN_W'(1)) == eff_len);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      arvr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (is_pull && ring_pull) ? arvr_pkg::ST_RD : arvr_pkg::ST_DONE;
        end
      end
      arvr_pkg::ST_RD:     state_next = arvr_pkg::ST_GSTART;
      arvr_pkg::ST_GSTART: begin
        state_next = (block_fill > arvr_pkg::LEN_W'(1)) ? arvr_pkg::ST_GWAIT : arvr_pkg::ST_MUL;
      end
      arvr_pkg::ST_GWAIT:  if (div_done) state_next = arvr_pkg::ST_MUL;
      arvr_pkg::ST_MUL:    state_next = arvr_pkg::ST_SCALE;
      arvr_pkg::ST_SCALE:  state_next = arvr_pkg::ST_DONE;
      arvr_pkg::ST_DONE:   if (!rsp.valid || rsp.ready) state_next = arvr_pkg::ST_IDLE;
      default:             state_next = arvr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready    = state == arvr_pkg::ST_IDLE;
    load_out     = (state == arvr_pkg::ST_DONE) && (!rsp.valid || rsp.ready);
    div_start    = (state == arvr_pkg::ST_GSTART) && (block_fill > arvr_pkg::LEN_W'(1));
    div_dividend = num_abs;
    div_divisor  = block_fill - arvr_pkg::LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arvr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  arvr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Ring memory
  always_ff @(posedge clk) begin
    if (accept && !is_pull && !full) begin
      ring[write_index] <= req.data.sample_in;
    end
    ring_rdata <= ring[read_index];
  end

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= arvr_pkg::GAIN_W'(arvr_pkg::FULL_GAIN);
      mute   <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.addr)
        arvr_pkg::REG_VOLUME: volume <= cfg.wdata;
        arvr_pkg::REG_MUTE:   mute   <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  // Ring indexes and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      read_index     <= '0;
      previous_gain  <= '0;
      block_fill     <= '0;
      block_position <= '0;
      block_length   <= '0;
      ramp_start     <= '0;
      ramp_end       <= '0;
    end else if (accept) begin
      if (!is_pull) begin
        if (!full) begin
          write_index <= write_index + arvr_pkg::RING_AW'(1);
        end
      end else begin
        if (req.data.block_start) begin
          block_length  <= len_sat;
          block_fill    <= fill_new;
          ramp_start    <= previous_gain;
          ramp_end      <= target;
          previous_gain <= target;
        end
        block_position <= active ? eff_pos + arvr_pkg::LEN_W'(1) : eff_pos;
        if (ring_pull) begin
          read_index <= read_index + arvr_pkg::RING_AW'(1);
        end
      end
    end
  end

  // Datapath: ramp gain, scaling, result
  logic signed [arvr_pkg::GAIN_W:0]          diff;
  logic signed [arvr_pkg::GAIN_W+arvr_pkg::LEN_W+1:0] num;
  logic signed [arvr_pkg::GAIN_W+1:0]        gain_w;
  logic signed [arvr_pkg::SAMPLE_W+arvr_pkg::GAIN_W:0] prod;
  logic [arvr_pkg::DIV_W+arvr_pkg::RCP_W-1:0] scale_prod;
  logic [arvr_pkg::SAMPLE_W-1:0]             q16;

  always_comb begin
    diff       = $signed({1'b0, ramp_end}) - $signed({1'b0, ramp_start});
    num        = diff * $signed({1'b0, pos_cur});
    gain_w     = num_neg ? ($signed({2'b0, ramp_start}) - $signed({1'b0, div_quotient[7:0]}))
                         : ($signed({2'b0, ramp_start}) + $signed({1'b0, div_quotient[7:0]}));
    prod       = sample_q * $signed({1'b0, gain_q});
    scale_prod = prod_abs * arvr_pkg::RCP_100;
    q16        = scale_prod[arvr_pkg::RCP_SHIFT +: arvr_pkg::SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    case (state)
      arvr_pkg::ST_IDLE: begin
        if (accept) begin
          pos_cur           <= eff_pos;
          res.sample_out    <= '0;
          res.push_accepted <= !is_pull && !full;
          res.from_ring     <= is_pull && ring_pull;
          res.block_last    <= is_pull && is_last;
        end
      end
      arvr_pkg::ST_RD: begin
        sample_q <= ring_rdata;
        num_neg  <= num[$bits(num)-1];
        num_abs  <= arvr_pkg::DIV_W'(num[$bits(num)-1] ? -num : num);
      end
      arvr_pkg::ST_GSTART: begin
        if (block_fill <= arvr_pkg::LEN_W'(1)) begin
          gain_q <= ramp_end;
        end
      end
      arvr_pkg::ST_GWAIT: begin
        if (div_done) begin
          gain_q <= gain_w[arvr_pkg::GAIN_W-1:0];
        end
      end
      arvr_pkg::ST_MUL: begin
        prod_neg <= prod[$bits(prod)-1];
        prod_abs <= arvr_pkg::DIV_W'(prod[$bits(prod)-1] ? -prod : prod);
      end
      arvr_pkg::ST_SCALE: begin
        res.sample_out <= prod_neg ? $signed(arvr_pkg::SAMPLE_W'(0) - q16) : $signed(q16);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.data <= res;
    end
  end

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == arvr_pkg::ST_GWAIT))
    else $error("divider finished outside the wait state");

  a_ring_pull_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && is_pull && ring_pull) |=> (state == arvr_pkg::ST_RD))
    else $error("ring pull did not start a memory read");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    block_position <= block_length)
    else $error("block position past block length");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    block_fill <= block_length)
    else $error("block fill exceeds block length");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == arvr_pkg::ST_MUL) |-> (gain_q <= arvr_pkg::GAIN_W'(arvr_pkg::FULL_GAIN)))
    else $error("interpolated gain above full scale");

endmodule
`default_nettype wire

// File: test/audio_ring_volume_ramp_tb.sv
// Testbench for audio_ring_volume_ramp: directed cases, a partial ring fill and drain, then
// random push/pull traffic with register changes and random stalls on both channels.
// Depends on arvr_pkg, arvr_if.sv (interfaces) and the audio_ring_volume_ramp RTL.

class gain_ramp_sb;
  logic signed [arvr_pkg::SAMPLE_W-1:0] ring_mem [arvr_pkg::RING_DEPTH];
  logic [arvr_pkg::RING_AW-1:0] wr_ptr;
  logic [arvr_pkg::RING_AW-1:0] rd_ptr;
  int prev_gain;
  int fill;
  int pos;
  int blk_len;
  int g_from;
  int g_to;
  int volume;
  int muted;
  int errors;
  int outputs_seen;
  arvr_pkg::rsp_item_t due_outputs[$];

  function new();
    wr_ptr = '0;
    rd_ptr = '0;
    prev_gain = 0;
    fill = 0;
    pos = 0;
    blk_len = 0;
    g_from = 0;
    g_to = 0;
    volume = arvr_pkg::FULL_GAIN;
    muted = 0;
    errors = 0;
    outputs_seen = 0;
  endfunction

  function int pending();
    return due_outputs.size();
  endfunction

  task report(string what, int got_v, int exp_v);
    $display("MISMATCH output %0d %s: got %0d expected %0d", outputs_seen, what, got_v, exp_v);
    errors++;
  endtask

  function void note_register(logic [arvr_pkg::CFG_AW-1:0] addr,
                              logic [arvr_pkg::CFG_DW-1:0] val);
    if (addr == arvr_pkg::REG_VOLUME) volume = int'(val);
    else if (addr == arvr_pkg::REG_MUTE) muted = int'(val[0]);
  endfunction

  // computes the output for one accepted request transaction
  function void note_request(arvr_pkg::req_item_t it);
    arvr_pkg::rsp_item_t r;
    logic [arvr_pkg::RING_AW-1:0] used;
    int len;
    int tgt;
    int g;
    int s;
    r = '0;
    used = wr_ptr - rd_ptr;
    if (it.opcode == arvr_pkg::OP_PUSH) begin
      if (int'(used) < arvr_pkg::RING_DEPTH - 1) begin
        ring_mem[wr_ptr] = it.sample_in;
        wr_ptr = wr_ptr + arvr_pkg::RING_AW'(1);
        r.push_accepted = 1'b1;
      end
    end else begin
      if (it.block_start) begin
        len = int'(it.block_len);
        if (len == 0) len = 1;
        if (len > arvr_pkg::MAX_BLOCK) len = arvr_pkg::MAX_BLOCK;
        blk_len = len;
        fill = (int'(used) < len) ? int'(used) : len;
        pos = 0;
        tgt = (volume > arvr_pkg::FULL_GAIN) ? arvr_pkg::FULL_GAIN : volume;
        if (muted != 0) tgt = 0;
        g_from = prev_gain;
        g_to = tgt;
        prev_gain = tgt;
      end
      if (pos < blk_len) begin
        if (pos < fill) begin
          g = (fill > 1) ? g_from + (g_to - g_from) * pos / (fill - 1) : g_to;
          s = int'(ring_mem[rd_ptr]);
          r.sample_out = arvr_pkg::SAMPLE_W'(s * g / arvr_pkg::FULL_GAIN);
          r.from_ring = 1'b1;
          rd_ptr = rd_ptr + arvr_pkg::RING_AW'(1);
        end
        if (pos + 1 == blk_len) r.block_last = 1'b1;
        pos++;
      end
    end
    due_outputs.push_back(r);
  endfunction

  task check_output(arvr_pkg::rsp_item_t got);
    arvr_pkg::rsp_item_t exp_r;
    outputs_seen++;
    if (due_outputs.size() == 0) begin
      report("unexpected transaction", int'(got), 0);
      return;
    end
    exp_r = due_outputs.pop_front();
    if (got.sample_out !== exp_r.sample_out)
      report("sample_out", int'(got.sample_out), int'(exp_r.sample_out));
    if (got.push_accepted !== exp_r.push_accepted)
      report("push_accepted", int'(got.push_accepted), int'(exp_r.push_accepted));
    if (got.from_ring !== exp_r.from_ring)
      report("from_ring", int'(got.from_ring), int'(exp_r.from_ring));
    if (got.block_last !== exp_r.block_last)
      report("block_last", int'(got.block_last), int'(exp_r.block_last));
  endtask
endclass

module audio_ring_volume_ramp_tb;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int RAND_ITEMS = 1340;
  localparam int PRELOAD = 120;
  localparam int DRAIN_PULLS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;

  logic clk;
  logic rst;
  bit calm;
  bit hold_rsp;
  int cycle_count = 0;
  int item_count = 0;
  gain_ramp_sb sb;

  arvr_req_if req_ch();
  arvr_rsp_if rsp_ch();
  arvr_cfg_if cfg_ch();

  audio_ring_volume_ramp u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_output(rsp_ch.data);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int rnd_sample();
    case ($urandom_range(0, 11))
      0: return 32767;
      1: return -32768;
      2: return -1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rnd_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 85) return $urandom_range(17, 64);
    if (r < 90) return 0;
    if (r < 95) return arvr_pkg::MAX_BLOCK;
    return $urandom_range(arvr_pkg::MAX_BLOCK + 1, 2047);
  endfunction

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int idle_left;
    idle_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        idle_left = HOLD_CYCLES;
      end
      if (idle_left > 0) begin
        rsp_ch.ready <= 1'b0;
        idle_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        idle_left = pick_gap();
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // valid stays high after a transaction until the next send or req_idle
  task automatic send(logic op, int smp, int st, int len);
    arvr_pkg::req_item_t it;
    int gap;
    it.opcode = op;
    it.sample_in = arvr_pkg::SAMPLE_W'(smp);
    it.block_start = 1'(st);
    it.block_len = arvr_pkg::LEN_W'(len);
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(it);
    item_count++;
  endtask

  task automatic req_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    req_idle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [arvr_pkg::CFG_AW-1:0] addr, int val);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= addr;
    cfg_ch.wdata <= arvr_pkg::CFG_DW'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    sb.note_register(addr, arvr_pkg::CFG_DW'(val));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_config();
    int vol;
    case ($urandom_range(0, 5))
      0: vol = 0;
      1: vol = arvr_pkg::FULL_GAIN;
      2: vol = arvr_pkg::FULL_GAIN + 1;
      3: vol = 127;
      default: vol = $urandom_range(0, 127);
    endcase
    if ($urandom_range(0, 2) != 0) cfg_write(arvr_pkg::REG_VOLUME, vol);
    if ($urandom_range(0, 1) == 0)
      cfg_write(arvr_pkg::REG_MUTE, ($urandom_range(0, 3) == 0) ? 1 : 0);
  endtask

  initial begin
    int k;
    int n;
    int len;
    int eff;
    int stop_at;
    sb = new();
    calm = 1'b0;
    hold_rsp = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    send(arvr_pkg::OP_PULL, 0, 0, 0);
    send(arvr_pkg::OP_PUSH, 32767, 1, 2047);
    send(arvr_pkg::OP_PUSH, -32768, 0, 0);
    send(arvr_pkg::OP_PUSH, -1, 0, 0);
    send(arvr_pkg::OP_PUSH, 1, 0, 0);
    send(arvr_pkg::OP_PUSH, 12345, 0, 0);
    send(arvr_pkg::OP_PUSH, -12345, 0, 0);
    send(arvr_pkg::OP_PULL, 0, 1, 0);
    send(arvr_pkg::OP_PULL, 0, 0, 5);
    cfg_write(arvr_pkg::REG_MUTE, 1);
    send(arvr_pkg::OP_PULL, 0, 1, 3);
    send(arvr_pkg::OP_PULL, 0, 0, 0);
    send(arvr_pkg::OP_PULL, 0, 0, 0);
    cfg_write(arvr_pkg::REG_MUTE, 0);
    cfg_write(arvr_pkg::REG_VOLUME, 127);
    send(arvr_pkg::OP_PULL, -1, 1, 2047);
    send(arvr_pkg::OP_PULL, 0, 0, 0);
    send(arvr_pkg::OP_PULL, 0, 0, 0);
    send(arvr_pkg::OP_PULL, 0, 1, 1);
    cfg_write(arvr_pkg::REG_VOLUME, 37);
    send(arvr_pkg::OP_PUSH, 1000, 0, 0);
    send(arvr_pkg::OP_PUSH, -999, 0, 0);
    send(arvr_pkg::OP_PUSH, 32767, 0, 0);
    send(arvr_pkg::OP_PULL, 0, 1, 5);
    send(arvr_pkg::OP_PULL, 0, 0, 0);
    send(arvr_pkg::OP_PULL, 0, 1, 4);
    repeat (3) send(arvr_pkg::OP_PULL, 0, 0, 0);

    // part-fill the ring, then drain it in long blocks across gain changes
    cfg_write(arvr_pkg::REG_VOLUME, arvr_pkg::FULL_GAIN);
    repeat (PRELOAD) send(arvr_pkg::OP_PUSH, rnd_sample(), $urandom_range(0, 1), 0);
    for (int b = 0; b < 4; b++) begin
      case (b)
        1: cfg_write(arvr_pkg::REG_VOLUME, 0);
        2: begin
          cfg_write(arvr_pkg::REG_VOLUME, 63);
          cfg_write(arvr_pkg::REG_MUTE, 1);
        end
        3: begin
          cfg_write(arvr_pkg::REG_MUTE, 0);
          cfg_write(arvr_pkg::REG_VOLUME, 127);
        end
        default: ;
      endcase
      send(arvr_pkg::OP_PULL, 0, 1, (b == 1) ? 2047 : arvr_pkg::MAX_BLOCK);
      for (k = 1; k < DRAIN_PULLS; k++) begin
        if (b == 0 && k == 10) hold_rsp = 1'b1;
        send(arvr_pkg::OP_PULL, rnd_sample(), 0, $urandom_range(0, 2047));
      end
    end

    // random traffic
    stop_at = item_count + RAND_ITEMS;
    while (item_count < stop_at) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        repeat ($urandom_range(1, 24))
          send(arvr_pkg::OP_PUSH, rnd_sample(), $urandom_range(0, 1), $urandom_range(0, 2047));
      end else if (k < 75) begin
        len = rnd_len();
        eff = (len == 0) ? 1 : ((len > arvr_pkg::MAX_BLOCK) ? arvr_pkg::MAX_BLOCK : len);
        send(arvr_pkg::OP_PULL, rnd_sample(), 1, len);
        n = (eff <= 64) ? eff - 1 : $urandom_range(0, 30);
        if ($urandom_range(0, 6) == 0) n = $urandom_range(0, n);
        for (int p = 0; p < n; p++) begin
          if ($urandom_range(0, 9) == 0)
            send(arvr_pkg::OP_PUSH, rnd_sample(), $urandom_range(0, 1), $urandom_range(0, 2047));
          send(arvr_pkg::OP_PULL, rnd_sample(), 0, $urandom_range(0, 2047));
        end
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) send(arvr_pkg::OP_PULL, rnd_sample(), 0, rnd_len());
      end else if (k < 85) begin
        repeat ($urandom_range(1, 3)) send(arvr_pkg::OP_PULL, rnd_sample(), 0, rnd_len());
      end else if (k < 93) begin
        random_config();
      end else begin
        wait_drained();
        calm = !calm;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
